FILE: rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg: shared types, constants and functions of the telemetry frame parser
// Holds the register indexes, result status codes, the result record that
// travels to the output stage and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package tfp_pkg;

    // Default longest frame, sync and length bytes included
    localparam int MAX_FRAME_DEF = 64;

    // CRC-8 polynomial, MSB first, initial value zero
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Reset values of the configuration registers
    localparam logic [7:0] SYNC_RESET    = 8'd200;
    localparam logic [7:0] LINK_RESET    = 8'd20;
    localparam logic [7:0] BATTERY_RESET = 8'd8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SYNC    = 2'd0,
        REG_LINK    = 2'd1,
        REG_BATTERY = 2'd2,
        REG_NONE    = 2'd3
    } tfp_reg_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LINK    = 2'd0,
        ST_BATTERY = 2'd1,
        ST_OTHER   = 2'd2,
        ST_CRC_ERR = 2'd3
    } tfp_status_t;

    // Configuration register contents
    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] link_type_code;
        logic [7:0] battery_type_code;
    } tfp_cfg_t;

    // One result request
    typedef struct packed {
        tfp_status_t        frame_status;
        logic [7:0]         frame_type;
        logic [7:0]         uplink_rssi;
        logic [7:0]         downlink_rssi;
        logic [7:0]         link_qual;
        logic signed [7:0]  signal_noise;
        logic [15:0]        battery_voltage;
        logic [15:0]        battery_current;
        logic [23:0]        used_capacity;
        logic [7:0]         remaining_percent;
    } tfp_result_t;

    // Output stream widths
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 10;

    // Fold one byte into the running CRC-8
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/tfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfp_cfg_regs: configuration registers
// Write-only register file holding the sync byte and the two frame type codes.
// ----------------------------------------------------------------------------
module tfp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tfp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tfp_pkg::tfp_cfg_t             cfg
);
    import tfp_pkg::*;

    tfp_cfg_t cfg_reg;
    tfp_cfg_t cfg_next;

    // Decode the write index; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (tfp_reg_t'(cfg_addr))
                REG_SYNC:    cfg_next.sync_value        = cfg_wdata;
                REG_LINK:    cfg_next.link_type_code    = cfg_wdata;
                REG_BATTERY: cfg_next.battery_type_code = cfg_wdata;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value        <= SYNC_RESET;
            cfg_reg.link_type_code    <= LINK_RESET;
            cfg_reg.battery_type_code <= BATTERY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tfp_in_stage.sv
// ----------------------------------------------------------------------------
// tfp_in_stage: input register
// Captures one received byte per accepted request and holds it for the parser.
// ----------------------------------------------------------------------------
module tfp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);
    logic       valid_reg;
    logic [7:0] byte_reg;

    // Take a new byte whenever the held one is consumed or the stage is empty
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Hold the payload byte; no reset needed
    always_ff @(posedge clk)
    begin
        if (advance && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

FILE: rtl/tfp_parse_core.sv
// ----------------------------------------------------------------------------
// tfp_parse_core: frame parser
// Tracks the frame position, length and running CRC, stores frame positions
// 3..10, updates the held telemetry and forms one result per completed frame.
// ----------------------------------------------------------------------------
module tfp_parse_core #(
    parameter int MAX_FRAME = tfp_pkg::MAX_FRAME_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tfp_pkg::tfp_cfg_t      cfg,
    input  logic                   byte_valid,
    input  logic [7:0]             rx_byte,
    input  logic                   out_free,
    output logic                   advance,
    output logic                   res_valid,
    output tfp_pkg::tfp_result_t   res
);
    import tfp_pkg::*;

    localparam int         POS_W   = $clog2(MAX_FRAME);
    localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 2);

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [7:0]       len_reg,  len_next;
    logic [7:0]       crc_reg,  crc_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       store_reg [8];
    logic [7:0]       store_next [8];

    logic [7:0]  up_reg,   up_next;
    logic [7:0]  down_reg, down_next;
    logic [7:0]  lq_reg,   lq_next;
    logic [7:0]  snr_reg,  snr_next;
    logic [15:0] volt_reg, volt_next;
    logic [15:0] curr_reg, curr_next;
    logic [23:0] cap_reg,  cap_next;
    logic [7:0]  rem_reg,  rem_next;

    logic        in_frame;
    logic        at_end;
    logic        step;
    logic [7:0]  type_cur;
    logic        in_store;
    logic [2:0]  store_idx;
    tfp_status_t status;

    // Frame end: position reaches length plus one (the CRC byte)
    assign in_frame = (pos_reg != POS_W'(0)) && (pos_reg != POS_W'(1));
    assign at_end   = in_frame && ({1'b0, len_reg} + 9'd1 == 9'(pos_reg));

    // Stall only when this byte completes a frame and the output is full
    assign advance   = !byte_valid || !at_end || out_free;
    assign res_valid = byte_valid && at_end;
    assign step      = byte_valid && advance;

    assign type_cur  = (pos_reg == POS_W'(2)) ? rx_byte : type_reg;
    assign in_store  = (pos_reg >= POS_W'(3)) && (pos_reg <= POS_W'(10));
    assign store_idx = 3'(pos_reg - POS_W'(3));

    // Next parser state
    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        type_next = type_reg;
        for (int i = 0; i < 8; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (in_frame && in_store)
        begin
            store_next[store_idx] = rx_byte;
        end

        if (pos_reg == POS_W'(0))
        begin
            if (rx_byte == cfg.sync_value)
            begin
                pos_next = POS_W'(1);
                crc_next = 8'd0;
            end
        end
        else if (pos_reg == POS_W'(1))
        begin
            len_next = rx_byte;
            if (rx_byte == 8'd0 || rx_byte > LEN_MAX)
                pos_next = POS_W'(0);
            else
                pos_next = POS_W'(2);
        end
        else
        begin
            type_next = type_cur;
            if (at_end)
            begin
                pos_next = POS_W'(0);
            end
            else
            begin
                crc_next = crc8_step(crc_reg, rx_byte);
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Classify the completed frame; link wins when both codes match
    always_comb
    begin
        priority if (crc_reg != rx_byte)
            status = ST_CRC_ERR;
        else if (type_cur == cfg.link_type_code)
            status = ST_LINK;
        else if (type_cur == cfg.battery_type_code)
            status = ST_BATTERY;
        else
            status = ST_OTHER;
    end

    // Update the held telemetry from the store, last byte included
    always_comb
    begin
        up_next   = up_reg;
        down_next = down_reg;
        lq_next   = lq_reg;
        snr_next  = snr_reg;
        volt_next = volt_reg;
        curr_next = curr_reg;
        cap_next  = cap_reg;
        rem_next  = rem_reg;
        if (at_end && status == ST_LINK)
        begin
            up_next   = store_next[0];
            down_next = store_next[1];
            lq_next   = store_next[2];
            snr_next  = store_next[3];
        end
        if (at_end && status == ST_BATTERY)
        begin
            volt_next = {store_next[0], store_next[1]};
            curr_next = {store_next[2], store_next[3]};
            cap_next  = {store_next[4], store_next[5], store_next[6]};
            rem_next  = store_next[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            crc_reg  <= '0;
            type_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                store_reg[i] <= '0;
            end
            up_reg   <= '0;
            down_reg <= '0;
            lq_reg   <= '0;
            snr_reg  <= '0;
            volt_reg <= '0;
            curr_reg <= '0;
            cap_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            type_reg <= type_next;
            for (int i = 0; i < 8; i++)
            begin
                store_reg[i] <= store_next[i];
            end
            up_reg   <= up_next;
            down_reg <= down_next;
            lq_reg   <= lq_next;
            snr_reg  <= snr_next;
            volt_reg <= volt_next;
            curr_reg <= curr_next;
            cap_reg  <= cap_next;
            rem_reg  <= rem_next;
        end
    end

    // Result record for the output stage
    always_comb
    begin
        res.frame_status      = status;
        res.frame_type        = type_cur;
        res.uplink_rssi       = up_next;
        res.downlink_rssi     = down_next;
        res.link_qual         = lq_next;
        res.signal_noise      = snr_next;
        res.battery_voltage   = volt_next;
        res.battery_current   = curr_next;
        res.used_capacity     = cap_next;
        res.remaining_percent = rem_next;
    end

endmodule

FILE: rtl/tfp_out_stage.sv
// ----------------------------------------------------------------------------
// tfp_out_stage: result register
// Holds one result request until the downstream side takes it and packs the
// fields onto the output stream.
// ----------------------------------------------------------------------------
module tfp_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    input  tfp_pkg::tfp_result_t              res,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [tfp_pkg::OUT_USER_W-1:0]    m_tuser
);
    import tfp_pkg::*;

    logic        valid_reg;
    tfp_result_t res_reg;

    // Register is free when empty or being drained this cycle
    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    // Pack the stream fields, uplink_rssi in the lowest bits
    assign m_tvalid = valid_reg;
    assign m_tuser  = {res_reg.frame_type, res_reg.frame_status};
    assign m_tdata  = {res_reg.remaining_percent,
                       res_reg.used_capacity,
                       res_reg.battery_current,
                       res_reg.battery_voltage,
                       res_reg.signal_noise,
                       res_reg.link_qual,
                       res_reg.downlink_rssi,
                       res_reg.uplink_rssi};

endmodule

FILE: rtl/telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// telemetry_frame_parser: serial telemetry frame parser
// Path: a completed frame's CRC byte is captured by the input register, and its
// result is then captured by the result register, which drives the output.
// Throughput: one byte per cycle; the parser stalls input only when a byte
// ends a frame while the result register still holds an untaken result.
// Reset: asynchronous, active low; hunting for sync, held telemetry zero,
// registers at protocol defaults.
// ----------------------------------------------------------------------------
module telemetry_frame_parser #(
    parameter int MAX_FRAME = tfp_pkg::MAX_FRAME_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] uplink_rssi, [15:8] downlink_rssi, [23:16] link_qual,
    // [31:24] signal_noise, [47:32] battery_voltage, [63:48] battery_current,
    // [87:64] used_capacity, [95:88] remaining_percent
    output logic [tfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] frame_status, [9:2] frame_type
    output logic [tfp_pkg::OUT_USER_W-1:0]    m_tuser,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tfp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tfp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tfp_pkg::*;

    tfp_cfg_t    cfg;
    tfp_result_t res;
    logic        advance;
    logic        byte_valid;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        out_free;

    tfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    tfp_parse_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .out_free   (out_free),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    tfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/tfp_checker.sv
// ----------------------------------------------------------------------------
// tfp_checker: port-level checks for the telemetry frame parser
// Checks output hold, input readiness and which held fields each status may
// change between successive results.
// ----------------------------------------------------------------------------
module tfp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [tfp_pkg::OUT_USER_W-1:0]    m_tuser
);
    import tfp_pkg::*;

    logic [OUT_DATA_W-1:0] last_data_reg;
    logic                  out_take;
    tfp_status_t           cur_status;

    assign out_take   = m_tvalid && m_tready;
    assign cur_status = tfp_status_t'(m_tuser[1:0]);

    // Track the held telemetry of the last taken result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_data_reg <= '0;
        end
        else if (out_take)
        begin
            last_data_reg <= m_tdata;
        end
    end

    // A pending result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // An empty result register never blocks input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // CRC error or other type leaves all held fields alone
    a_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (cur_status == ST_OTHER || cur_status == ST_CRC_ERR)
        |-> m_tdata == last_data_reg)
        else $error("held telemetry changed without update");

    // A link update leaves battery fields alone
    a_link_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && cur_status == ST_LINK
        |-> m_tdata[95:32] == last_data_reg[95:32])
        else $error("link frame changed battery fields");

    // A battery update leaves link fields alone
    a_batt_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && cur_status == ST_BATTERY
        |-> m_tdata[31:0] == last_data_reg[31:0])
        else $error("battery frame changed link fields");

endmodule

bind telemetry_frame_parser tfp_checker u_tfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the telemetry frame parser
// Streams serial bytes (fixed edge cases, register sweeps, then random framed
// traffic with noise and broken frames) under several idling mixes, predicts
// each frame result from a local parser model and checks every field.
// ----------------------------------------------------------------------------
module testbench;

    import tfp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int MAX_LEN      = MAX_FRAME_DEF - 2;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 440;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Idling mix of the current phase
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int bytes_sent     = 0;

    // Local copy of the parser: registers, frame state and held telemetry
    logic [7:0]  sync_v    = SYNC_RESET;
    logic [7:0]  link_code = LINK_RESET;
    logic [7:0]  batt_code = BATTERY_RESET;
    int          parse_pos = 0;
    int          frame_len = 0;
    logic [7:0]  crc_acc   = 8'h00;
    logic [7:0]  cur_type  = 8'h00;
    logic [7:0]  payload [8] = '{default: 8'h00};
    tfp_result_t held_telemetry = '0;

    tfp_result_t expected_frames[$];

    telemetry_frame_parser #(
        .MAX_FRAME (MAX_FRAME_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Fold one byte into the CRC, one data bit at a time, MSB first
    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[7] ^ b[i])
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // Advance the local parser by one accepted byte; queue a result at frame end
    function automatic void parse_rx_byte(input logic [7:0] b);
        tfp_result_t res;
        if (parse_pos == 0)
        begin
            if (b == sync_v)
            begin
                parse_pos = 1;
                crc_acc   = 8'h00;
            end
        end
        else if (parse_pos == 1)
        begin
            frame_len = b;
            parse_pos = (b == 0 || b > MAX_LEN) ? 0 : 2;
        end
        else
        begin
            if (parse_pos == 2)
                cur_type = b;
            if (parse_pos >= 3 && parse_pos <= 10)
                payload[parse_pos - 3] = b;
            if (parse_pos != frame_len + 1)
            begin
                crc_acc   = crc_fold(crc_acc, b);
                parse_pos = parse_pos + 1;
            end
            else
            begin
                parse_pos = 0;
                if (crc_acc != b)
                    held_telemetry.frame_status = ST_CRC_ERR;
                else if (cur_type == link_code)
                begin
                    held_telemetry.frame_status  = ST_LINK;
                    held_telemetry.uplink_rssi   = payload[0];
                    held_telemetry.downlink_rssi = payload[1];
                    held_telemetry.link_qual     = payload[2];
                    held_telemetry.signal_noise  = payload[3];
                end
                else if (cur_type == batt_code)
                begin
                    held_telemetry.frame_status      = ST_BATTERY;
                    held_telemetry.battery_voltage   = {payload[0], payload[1]};
                    held_telemetry.battery_current   = {payload[2], payload[3]};
                    held_telemetry.used_capacity     = {payload[4], payload[5], payload[6]};
                    held_telemetry.remaining_percent = payload[7];
                end
                else
                    held_telemetry.frame_status = ST_OTHER;
                held_telemetry.frame_type = cur_type;
                res = held_telemetry;
                expected_frames.push_back(res);
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver side: stall at the rate of the current phase
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_frames.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Track accepted bytes and check each result request against the oldest prediction
    always @(posedge clk)
    begin : result_check
        tfp_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tuser %0h tdata %0h",
                             $time, m_tuser, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    compare_field("frame_status", want.frame_status, m_tuser[1:0]);
                    compare_field("frame_type", want.frame_type, m_tuser[9:2]);
                    compare_field("uplink_rssi", want.uplink_rssi, m_tdata[7:0]);
                    compare_field("downlink_rssi", want.downlink_rssi, m_tdata[15:8]);
                    compare_field("link_qual", want.link_qual, m_tdata[23:16]);
                    compare_field("signal_noise", unsigned'(want.signal_noise),
                                  m_tdata[31:24]);
                    compare_field("battery_voltage", want.battery_voltage, m_tdata[47:32]);
                    compare_field("battery_current", want.battery_current, m_tdata[63:48]);
                    compare_field("used_capacity", want.used_capacity, m_tdata[87:64]);
                    compare_field("remaining_percent", want.remaining_percent,
                                  m_tdata[95:88]);
                end
            end
        end
    end

    // Present one byte and hold it until the parser takes it; returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        bytes_sent++;
    endtask

    // Sync, length, type, body and CRC; optionally corrupt the CRC
    task automatic send_frame(input logic [7:0] ftype, input byte_q_t body, input bit bad_crc);
        logic [7:0] acc;
        logic [7:0] flip;
        acc  = crc_fold(8'h00, ftype);
        flip = 8'($urandom_range(255, 1));
        send_byte(sync_v);
        send_byte(8'(body.size() + 2));
        send_byte(ftype);
        foreach (body[k])
        begin
            send_byte(body[k]);
            acc = crc_fold(acc, body[k]);
        end
        send_byte(bad_crc ? (acc ^ flip) : acc);
    endtask

    // Length one: the single byte is both type and CRC
    task automatic send_bare_frame(input logic [7:0] b);
        send_byte(sync_v);
        send_byte(8'd1);
        send_byte(b);
    endtask

    // Write a register and mirror it; call only while the parser is idle (unchecked)
    task automatic write_reg(input tfp_reg_t idx, input logic [7:0] v);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_SYNC:    sync_v    = v;
            REG_LINK:    link_code = v;
            REG_BATTERY: batt_code = v;
            default:     ;
        endcase
    endtask

    // Wait for every predicted result, then let the pipeline settle
    task automatic wait_drained();
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Byte extremes, dropped lengths, length one, stale payload, CRC mismatch
    task automatic test_frame_edges();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sync_v);
        send_byte(8'd0);
        send_byte(sync_v);
        send_byte(8'(MAX_LEN + 1));
        send_bare_frame(8'h00);
        send_frame(batt_code, {8'hA5}, 1'b0);
        send_frame(link_code, {8'hFF, 8'h00, 8'h80, 8'h7F}, 1'b0);
        send_frame(link_code, {8'h55}, 1'b1);
        wait_drained();
    endtask

    // Register extremes, equal type codes, length one frame hitting the link code
    task automatic test_type_codes();
        write_reg(REG_SYNC, 8'h00);
        write_reg(REG_LINK, 8'hFF);
        write_reg(REG_BATTERY, 8'hFF);
        send_frame(8'hFF, {8'h01, 8'h02, 8'h03, 8'h04}, 1'b0);
        send_frame(8'hFF, {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88}, 1'b0);
        wait_drained();
        write_reg(REG_SYNC, 8'hFF);
        write_reg(REG_LINK, 8'h00);
        write_reg(REG_BATTERY, 8'h7F);
        send_bare_frame(8'h00);
        send_frame(8'h7F, {8'hFF, 8'hFE, 8'h80, 8'h01, 8'hFF, 8'h00, 8'hC3, 8'h64}, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed frames with random content, plus noise and broken frames
    task automatic send_random_traffic(input int n_bytes);
        byte_q_t    body;
        logic [7:0] ftype;
        logic [7:0] b;
        int         pick;
        int         len;
        int         target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(99);
            body.delete();
            if (pick < 75)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    ftype = link_code;
                else if (pick < 75)
                    ftype = batt_code;
                else
                    ftype = 8'($urandom_range(255));
                len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN, 13)
                                               : $urandom_range(12, 1);
                if (len == 1)
                    send_bare_frame(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255)));
                else
                begin
                    for (int k = 0; k < len - 2; k++)
                        body.push_back(8'($urandom_range(255)));
                    send_frame(ftype, body, $urandom_range(9) == 0);
                end
            end
            else if (pick < 85)
            begin
                // line noise while hunting
                repeat ($urandom_range(4, 1))
                begin
                    b = 8'($urandom_range(255));
                    send_byte((b == sync_v) ? (b ^ 8'h01) : b);
                end
            end
            else if (pick < 95)
            begin
                // sync followed by a length the parser must drop
                send_byte(sync_v);
                send_byte(($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255, MAX_LEN + 1)));
            end
            else
            begin
                // cut-off frame: what follows is taken as its remainder
                send_byte(sync_v);
                send_byte(8'($urandom_range(MAX_LEN, 1)));
                repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // One random phase: registers first, then traffic under the given idling mix
    task automatic test_random_phase(input int src_pct, input int sink_pct,
                                     input logic [7:0] sync_set, input logic [7:0] link_set,
                                     input logic [7:0] batt_set);
        write_reg(REG_SYNC, sync_set);
        write_reg(REG_LINK, link_set);
        write_reg(REG_BATTERY, batt_set);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        send_random_traffic(PHASE_BYTES);
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_SYNC;
        cfg_wdata = 8'h00;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_frame_edges();
        test_type_codes();
        test_random_phase(0, 0, SYNC_RESET, LINK_RESET, BATTERY_RESET);
        test_random_phase(58, 0, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255)));
        test_random_phase(0, 58, 8'h00, 8'h00, 8'hFF);
        test_random_phase(27, 27, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: telemetry_frame_parser.f
rtl/tfp_pkg.sv
rtl/tfp_cfg_regs.sv
rtl/tfp_in_stage.sv
rtl/tfp_parse_core.sv
rtl/tfp_out_stage.sv
rtl/telemetry_frame_parser.sv
rtl/tfp_checker.sv
sim/testbench.sv
